// File: rtl/fwbeu_pkg.sv
// fwbeu_pkg: shared widths, register indexes and width-code helpers for the
// fixed-width big-endian unpacker. No dependencies.
`default_nettype none

package fwbeu_pkg;

   localparam int ByteW    = 8;
   localparam int ValueW   = 64;
   localparam int AccW     = 56;
   localparam int CodeW    = 4;
   localparam int RunW     = 16;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 16;
   localparam int CntW     = 4;

   typedef logic [CsrIdxW-1:0] csr_index_type;
   typedef logic [CodeW-1:0]   width_code_type;

   // register indexes on the csr port
   localparam csr_index_type CSR_WIDTH_CODE = 1'b0;
   localparam csr_index_type CSR_RUN_LENGTH = 1'b1;

   // width codes with special meaning
   localparam width_code_type CODE_W1    = 4'd0;
   localparam width_code_type CODE_W2    = 4'd1;
   localparam width_code_type CODE_W4    = 4'd2;
   localparam width_code_type CODE_W8    = 4'd3;
   localparam width_code_type CODE_W64   = 4'd10;
   localparam width_code_type CODE_RESET = CODE_W8;

   // bytes per value for byte-wide codes; unused codes mean 64 bits
   function automatic logic [CntW-1:0] bytes_of_code(input width_code_type code);
      logic [CntW-1:0] nb;
      if (code >= CODE_W8 && code <= CODE_W64) begin
         nb = code - 4'd2;
      end else begin
         nb = 4'd8;
      end
      return nb;
   endfunction

   // low 8*nb bits set, nb in 1..8
   function automatic logic [ValueW-1:0] value_mask(input logic [CntW-1:0] nb);
      logic [6:0] bits;
      bits = {nb, 3'b000};
      return {ValueW{1'b1}} >> (7'd64 - bits);
   endfunction

   // values held in one byte for narrow codes
   function automatic logic [CntW-1:0] values_per_byte(input width_code_type code);
      logic [CntW-1:0] per;
      unique case (code)
         CODE_W1: begin
            per = 4'd8;
         end
         CODE_W2: begin
            per = 4'd4;
         end
         default: begin
            per = 4'd2;
         end
      endcase
      return per;
   endfunction

endpackage

`default_nettype wire

// File: rtl/fixed_width_big_endian_unpacker.sv
// fixed_width_big_endian_unpacker: unpacks fixed-width values, msb first,
// from a byte stream into runs with a last flag. Depends on fwbeu_pkg.
//
// A byte passes the emit stage and output register before its first value. Byte
// widths take one byte per cycle unless rsp_stall holds the output; 1/2/4-bit widths
// emit one value per cycle unless stalled; the next byte waits till all are out.
// Reset (synchronous, active high): width code 8 bits, run length 1, no run
// open, accumulator empty, no beat pending on either channel.
`default_nettype none

module fixed_width_big_endian_unpacker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_we,
   input  wire fwbeu_pkg::csr_index_type      csr_index,
   input  wire logic [fwbeu_pkg::CsrDataW-1:0] csr_wdata,
   // byte input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fwbeu_pkg::ByteW-1:0]   req_in_byte,
   // value output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [fwbeu_pkg::ValueW-1:0]       rsp_value,
   output logic                               rsp_last
);
   import fwbeu_pkg::*;

   // configuration registers
   width_code_type      width_code_ff;
   logic [RunW-1:0]     run_length_ff;

   // run state
   logic [AccW-1:0]     acc_ff, acc_in;
   logic [CntW-2:0]     gathered_ff, gathered_in;
   logic [RunW-1:0]     left_ff, left_in;

   // emit stage
   logic [CntW-1:0]     wk_count_ff, wk_count_in;
   logic [ValueW-1:0]   wk_data_ff, wk_data_in;
   logic                wk_narrow_ff, wk_narrow_in;
   logic                wk_last_ff, wk_last_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ValueW-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_take;
   logic                move;
   logic                narrow;
   logic [RunW-1:0]     left_cur;
   logic [CntW-1:0]     per;
   logic [CntW-1:0]     n_narrow;
   logic [CntW-1:0]     nb;
   logic [ValueW-1:0]   full;
   logic                wide_done;
   logic [ValueW-1:0]   narrow_val;
   logic [ByteW-1:0]    narrow_shift;

   // handshake
   assign move      = (wk_count_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (wk_count_ff > 4'd1) || ((wk_count_ff == 4'd1) && !move);
   assign req_take  = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_code_ff <= CODE_RESET;
         run_length_ff <= RunW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_CODE: begin
               width_code_ff <= csr_wdata[CodeW-1:0];
            end
            default: begin
               run_length_ff <= csr_wdata[RunW-1:0];
            end
         endcase
      end
   end

   // per-byte decode
   always_comb begin
      narrow    = (width_code_ff <= CODE_W4);
      left_cur  = (left_ff != '0) ? left_ff :
                  ((run_length_ff == '0) ? RunW'(1) : run_length_ff);
      per       = values_per_byte(width_code_ff);
      n_narrow  = (left_cur < RunW'(per)) ? left_cur[CntW-1:0] : per;
      nb        = bytes_of_code(width_code_ff);
      full      = {acc_ff, req_in_byte};
      wide_done = ({1'b0, gathered_ff} + 4'd1) >= nb;
   end

   // run state and emit-stage load
   always_comb begin
      acc_in       = acc_ff;
      gathered_in  = gathered_ff;
      left_in      = left_ff;
      wk_count_in  = wk_count_ff;
      wk_data_in   = wk_data_ff;
      wk_narrow_in = wk_narrow_ff;
      wk_last_in   = wk_last_ff;
      if (move) begin
         wk_count_in = wk_count_ff - 4'd1;
         wk_data_in  = {wk_data_ff[ValueW-1:ByteW], narrow_shift};
      end
      if (req_take) begin
         if (narrow) begin
            acc_in       = '0;
            gathered_in  = '0;
            left_in      = left_cur - RunW'(n_narrow);
            wk_count_in  = n_narrow;
            wk_data_in   = {{(ValueW-ByteW){1'b0}}, req_in_byte};
            wk_narrow_in = 1'b1;
            wk_last_in   = (left_cur == RunW'(n_narrow));
         end else if (wide_done) begin
            acc_in       = '0;
            gathered_in  = '0;
            left_in      = left_cur - RunW'(1);
            wk_count_in  = 4'd1;
            wk_data_in   = full & value_mask(nb);
            wk_narrow_in = 1'b0;
            wk_last_in   = (left_cur == RunW'(1));
         end else begin
            acc_in      = full[AccW-1:0];
            gathered_in = gathered_ff + 3'd1;
            left_in     = left_cur;
         end
      end
   end

   // narrow value extraction, top bits first
   always_comb begin
      unique case (width_code_ff)
         CODE_W1: begin
            narrow_val   = ValueW'(wk_data_ff[7]);
            narrow_shift = {wk_data_ff[6:0], 1'b0};
         end
         CODE_W2: begin
            narrow_val   = ValueW'(wk_data_ff[7:6]);
            narrow_shift = {wk_data_ff[5:0], 2'b00};
         end
         default: begin
            narrow_val   = ValueW'(wk_data_ff[7:4]);
            narrow_shift = {wk_data_ff[3:0], 4'b0000};
         end
      endcase
   end

   // output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = wk_narrow_ff ? narrow_val : wk_data_ff;
         rsp_last_in  = wk_last_ff && (wk_count_ff == 4'd1);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         gathered_ff  <= '0;
         left_ff      <= '0;
         wk_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         gathered_ff  <= gathered_in;
         left_ff      <= left_in;
         wk_count_ff  <= wk_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wk_data_ff   <= wk_data_in;
      wk_narrow_ff <= wk_narrow_in;
      wk_last_ff   <= wk_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/fwbeu_checker.sv
// fwbeu_checker: port-level checks for the unpacker, bound to the top level.
// Depends on fwbeu_pkg and fixed_width_big_endian_unpacker.
`default_nettype none

module fwbeu_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [fwbeu_pkg::ValueW-1:0]   rsp_value,
   input  wire logic                           rsp_last
);
   import fwbeu_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   // a new result beat from an empty output follows an accepted byte through the emit stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("rsp beat without a byte behind it");

   // reset leaves both channels idle
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");

   // input only stalls behind a pending result or a byte just taken
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid || $past(req_valid && !req_stall))
      else $error("input stalled with nothing pending");

endmodule

bind fixed_width_big_endian_unpacker fwbeu_checker u_fwbeu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value),
   .rsp_last  (rsp_last)
);

`default_nettype wire
